// File: src/hermq_pkg.sv
// Shared widths, quadrature nodes and weights for the Hermite arc length unit.
`default_nettype none
package hermq_pkg;

  // Item layout.
  localparam int AXES   = 3;
  localparam int FIELDS = 12;
  localparam int IN_FW  = 32;
  localparam int IN_W   = FIELDS * IN_FW;
  localparam int OUT_W  = 40;

  // Quadrature nodes and weights, both Q0.24.
  localparam int NODES  = 5;
  localparam int T_W    = 24;
  localparam int HALF_T = 2 ** (T_W - 1);
  localparam int HALF_O = 2 ** T_W;

  // Datapath widths.
  localparam int C_W    = 37;             // c1, c2
  localparam int P1_W   = C_W + T_W + 1;  // c2 * t
  localparam int INR_W  = 38;             // c1 + rnd(c2 * t)
  localparam int P2_W   = INR_W + T_W + 1;// inner * t
  localparam int D_W    = P2_W - T_W;     // derivative, one axis
  localparam int AD_W   = 37;             // magnitude of one axis
  localparam int LO_W   = 19;
  localparam int HI_W   = AD_W - LO_W;
  localparam int SQ_W   = 2 * AD_W;
  localparam int RAD_W  = 76;
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;
  localparam int MW_W   = ROOT_W + T_W;
  localparam int ACC_W  = MW_W + 3;

  localparam logic [T_W-1:0] NODE_T [NODES] = '{
    24'd787020, 24'd3871600, 24'd8388608, 24'd12905616, 24'd15990196
  };
  localparam logic [T_W-1:0] NODE_W [NODES] = '{
    24'd3974973, 24'd8030057, 24'd9544372, 24'd8030057, 24'd3974973
  };

endpackage
`default_nettype wire

// File: src/hermq_sqrt.sv
// Pipelined integer square root, one result bit resolved in each stage.
`default_nettype none
module hermq_sqrt (
  input  logic                         clk,
  input  logic                         ce,
  input  logic [hermq_pkg::RAD_W-1:0]  rad,
  output logic [hermq_pkg::ROOT_W-1:0] root
);
  import hermq_pkg::*;

  logic [RAD_W-1:0]  rad_q  [ROOT_W];
  logic [REM_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];

  genvar g;
  for (g = 0; g < ROOT_W; g++) begin : g_stage
    logic [RAD_W-1:0]  cur_rad;
    logic [REM_W-1:0]  cur_rem;
    logic [ROOT_W-1:0] cur_root;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W:0]    diff;
    logic              ge;

    if (g == 0) begin : g_first
      assign cur_rad  = rad;
      assign cur_rem  = '0;
      assign cur_root = '0;
    end else begin : g_next
      assign cur_rad  = rad_q[g-1];
      assign cur_rem  = rem_q[g-1];
      assign cur_root = root_q[g-1];
    end

    // Bring down two radicand bits and try the next root bit.
    assign rem_sh = {cur_rem[REM_W-3:0], cur_rad[RAD_W-1:RAD_W-2]};
    assign diff   = {1'b0, rem_sh} - {1'b0, cur_root, 2'b01};
    assign ge     = !diff[REM_W];

    always_ff @(posedge clk) begin
      if (ce) begin
        rad_q[g]  <= cur_rad << 2;
        rem_q[g]  <= ge ? diff[REM_W-1:0] : rem_sh;
        root_q[g] <= {cur_root[ROOT_W-2:0], ge};
      end
    end
  end

  assign root = root_q[ROOT_W-1];

endmodule
`default_nettype wire

// File: src/hermite_arc_length_quadrature_unit.sv
// Top level: cubic Hermite segment arc length by five-point Gauss-Legendre quadrature.
//
//   channel  dir  width  contents
//   s_*      in   384    p0_x p0_y p0_z m0_x m0_y m0_z p1_x p1_y p1_z m1_x m1_y m1_z
//   m_*      out  40     arc_length
//
// One item enters per cycle while s_tready is high; each passes 50 register stages:
// 38 single-bit square root stages, eleven arithmetic stages and the output register.
// Reset clears the valid bits of the pipeline, the output register and the skid stage.
// The pipeline advances while the skid stage is empty, so a stalled output takes
// one more item before s_tready falls; nothing is dropped or repeated.
`default_nettype none
module hermite_arc_length_quadrature_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // p0_x, p0_y, p0_z, m0_x, m0_y, m0_z, p1_x, p1_y, p1_z, m1_x, m1_y, m1_z
  input  logic [hermq_pkg::IN_W-1:0]  s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // arc_length
  output logic [hermq_pkg::OUT_W-1:0] m_tdata
);
  import hermq_pkg::*;

  localparam int LAT = ROOT_W + 11;

  logic           ce;
  logic [LAT-1:0] v;
  logic           ov;
  logic           sv;
  logic [OUT_W-1:0] od;
  logic [OUT_W-1:0] sd;

  assign ce       = !sv;
  assign s_tready = ce;
  assign m_tvalid = ov;
  assign m_tdata  = od;

  // Valid bits travel beside the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (ce) begin
      v <= {v[LAT-2:0], s_tvalid};
    end
  end

  // Stage 1: derivative coefficients per axis.
  logic signed [IN_FW-1:0] s1_c0 [AXES];
  logic signed [C_W-1:0]   s1_c1 [AXES];
  logic signed [C_W-1:0]   s1_c2 [AXES];
  logic signed [IN_FW-1:0] s2_c0 [AXES];
  logic signed [C_W-1:0]   s2_c1 [AXES];
  logic signed [IN_FW-1:0] s3_c0 [AXES];
  logic signed [IN_FW-1:0] s4_c0 [AXES];

  genvar a, k;
  for (a = 0; a < AXES; a++) begin : g_axis
    logic signed [C_W-1:0] p0e, m0e, p1e, m1e, dp;
    assign p0e = C_W'($signed(s_tdata[a*IN_FW +: IN_FW]));
    assign m0e = C_W'($signed(s_tdata[(3+a)*IN_FW +: IN_FW]));
    assign p1e = C_W'($signed(s_tdata[(6+a)*IN_FW +: IN_FW]));
    assign m1e = C_W'($signed(s_tdata[(9+a)*IN_FW +: IN_FW]));
    assign dp  = p1e - p0e;

    always_ff @(posedge clk) begin
      if (ce) begin
        s1_c0[a] <= $signed(s_tdata[(3+a)*IN_FW +: IN_FW]);
        s1_c1[a] <= 37'sd6 * dp - 37'sd4 * m0e - 37'sd2 * m1e;
        s1_c2[a] <= 37'sd3 * (m0e + m1e) - 37'sd6 * dp;
        s2_c0[a] <= s1_c0[a];
        s2_c1[a] <= s1_c1[a];
        s3_c0[a] <= s2_c0[a];
        s4_c0[a] <= s3_c0[a];
      end
    end
  end

  // Stages 2 to 8: evaluate the derivative at each node, square it and sum the axes.
  logic [RAD_W-1:0]  s8_rad [NODES];
  logic [ROOT_W-1:0] root   [NODES];
  logic [MW_W-1:0]   s9_mw  [NODES];

  for (k = 0; k < NODES; k++) begin : g_node
    logic [SQ_W-1:0] s7_sq [AXES];

    for (a = 0; a < AXES; a++) begin : g_ax
      logic signed [P1_W-1:0]  s2_p1;
      logic signed [INR_W-1:0] s3_inner;
      logic signed [P2_W-1:0]  s4_p2;
      logic [AD_W-1:0]         s5_ad;
      logic [2*HI_W-1:0]       s6_hh;
      logic [HI_W+LO_W-1:0]    s6_hl;
      logic [2*LO_W-1:0]       s6_ll;
      logic signed [P1_W-1:0]  r1;
      logic signed [P2_W-1:0]  r2;
      logic signed [D_W-1:0]   d;
      logic signed [D_W-1:0]   dn;

      // Round half up: add a half, then floor by the arithmetic shift.
      assign r1 = s2_p1 + P1_W'(HALF_T);
      assign r2 = s4_p2 + P2_W'(HALF_T);
      assign d  = D_W'(s4_c0[a]) + $signed(r2[P2_W-1:T_W]);
      assign dn = -d;

      always_ff @(posedge clk) begin
        if (ce) begin
          s2_p1    <= s1_c2[a] * $signed({1'b0, NODE_T[k]});
          s3_inner <= INR_W'(s2_c1[a]) + $signed(r1[P1_W-1:T_W]);
          s4_p2    <= s3_inner * $signed({1'b0, NODE_T[k]});
          s5_ad    <= d[D_W-1] ? dn[AD_W-1:0] : d[AD_W-1:0];
          s6_hh    <= s5_ad[AD_W-1:LO_W] * s5_ad[AD_W-1:LO_W];
          s6_hl    <= s5_ad[AD_W-1:LO_W] * s5_ad[LO_W-1:0];
          s6_ll    <= s5_ad[LO_W-1:0] * s5_ad[LO_W-1:0];
          s7_sq[a] <= {s6_hh, (2*LO_W)'(0)} + (SQ_W'(s6_hl) << (LO_W + 1)) + SQ_W'(s6_ll);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        s8_rad[k] <= RAD_W'(s7_sq[0]) + RAD_W'(s7_sq[1]) + RAD_W'(s7_sq[2]);
        s9_mw[k]  <= root[k] * NODE_W[k];
      end
    end

    hermq_sqrt u_sqrt (
      .clk  (clk),
      .ce   (ce),
      .rad  (s8_rad[k]),
      .root (root[k])
    );
  end

  // Weighted sum over two stages, then round, halve and saturate.
  logic [MW_W:0]    s10_s01, s10_s23;
  logic [MW_W-1:0]  s10_p4;
  logic [ACC_W-1:0] s11_acc;
  logic [ACC_W:0]   out_rnd;
  logic [OUT_W:0]   out_sh;
  logic [OUT_W-1:0] res;

  always_ff @(posedge clk) begin
    if (ce) begin
      s10_s01 <= {1'b0, s9_mw[0]} + {1'b0, s9_mw[1]};
      s10_s23 <= {1'b0, s9_mw[2]} + {1'b0, s9_mw[3]};
      s10_p4  <= s9_mw[4];
      s11_acc <= ACC_W'(s10_s01) + ACC_W'(s10_s23) + ACC_W'(s10_p4);
    end
  end

  assign out_rnd = {1'b0, s11_acc} + (ACC_W+1)'(HALF_O);
  assign out_sh  = out_rnd[ACC_W:T_W+1];
  assign res     = out_sh[OUT_W] ? '1 : out_sh[OUT_W-1:0];

  // Output register with a skid stage behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (sv) begin
      if (m_tready) begin
        sv <= 1'b0;
      end
    end else if (ce && v[LAT-1]) begin
      if (ov && !m_tready) begin
        sv <= 1'b1;
      end else begin
        ov <= 1'b1;
      end
    end else if (m_tready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sv) begin
      if (m_tready) begin
        od <= sd;
      end
    end else if (ce && v[LAT-1]) begin
      if (ov && !m_tready) begin
        sd <= res;
      end else begin
        od <= res;
      end
    end
  end

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst) sv |-> ov)
    else $error("skid stage holds an item while the output register is empty");
  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
      (sv && m_tready) |=> (!sv && ov))
    else $error("skid stage did not move into the output register");
  a_item_lands: assert property (@(posedge clk) disable iff (rst)
      (ce && v[LAT-1] && !ov) |=> ov)
    else $error("finished item was not loaded into the output register");
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
      sv |=> (sv || ov))
    else $error("item lost while the pipeline was stalled");
`endif

endmodule
`default_nettype wire
